### sv/triangle_face_normal_assert.svh
// Assertion macros used by the tfn_back RTL file.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// same-cycle implication
`define TFN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and constants for the triangle face normal block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

  localparam int TargetBits = 30;
  localparam logic [15:0] NSat = 16'd32767;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vertex_t;

  typedef struct packed {
    vertex_t a;
    vertex_t b;
    vertex_t c;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
    logic               last_of_triangle;
  } result_t;

  // queue handshake between front and queue
  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

  function automatic logic signed [31:0] coord(input vertex_t v, input logic [1:0] i);
    logic signed [31:0] r;
    unique case (i)
      2'd0:    r = v.pos_x;
      2'd1:    r = v.pos_y;
      default: r = v.pos_z;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/tfn_queue.sv
// ----------------------------------------------------------------------------
// tfn_queue
// Two-entry triangle queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tfn_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tfn_pkg::tri_t wr_data,
  output logic               full,
  input  wire logic          pop,
  output logic               rd_valid,
  output tfn_pkg::tri_t      rd_data
);
  import tfn_pkg::*;

  tri_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && rd_valid) rd_ptr <= ~rd_ptr;
      case ({push && !full, pop && rd_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front
// Accepts vertices, holds the first two of a group, pushes whole triangles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tfn_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            vtx_valid,
  output logic                 vtx_stall,
  input  wire tfn_pkg::vertex_t vtx,
  output tfn_pkg::qwr_t        qwr,
  input  wire logic            q_full,
  output tfn_pkg::tri_t        q_data
);
  import tfn_pkg::*;

  vertex_t    held_a;
  vertex_t    held_b;
  logic [1:0] phase;
  logic       take;

  // phase 3 never arises; treated like 2
  assign vtx_stall = phase[1] && q_full;
  assign take      = vtx_valid && !vtx_stall;
  assign qwr.push  = take && phase[1];
  assign qwr.full  = q_full;
  assign q_data    = '{a: held_a, b: held_b, c: vtx};

  always_ff @(posedge clk) begin
    if (take && phase == 2'd0) held_a <= vtx;
    if (take && phase == 2'd1) held_b <= vtx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (take) begin
      phase <= phase[1] ? 2'd0 : phase + 2'd1;
    end
  end
endmodule
`default_nettype wire

### sv/tfn_back.sv
// ----------------------------------------------------------------------------
// tfn_back
// Computes the face normal of one queued triangle and emits its vertices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tfn_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire tfn_pkg::tri_t q_data,
  output logic               q_pop,
  output logic               res_valid,
  input  wire logic          res_stall,
  output tfn_pkg::result_t   res
);
  import tfn_pkg::*;
  `include "triangle_face_normal_assert.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_CROSS = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DIVI  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0]         state;
  tri_t               tri_q;
  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [65:0] prod [6];
  logic signed [66:0] crs [3];
  logic [65:0]        mag [3];
  logic               neg [3];
  logic [65:0]        orv;
  logic [59:0]        sq [3];
  logic [63:0]        sx;
  logic [63:0]        sres;
  logic [63:0]        sbit;
  logic [31:0]        dvs;
  logic [31:0]        rem [3];
  logic [16:0]        nlo [3];
  logic [16:0]        quo [3];
  logic [4:0]         dcnt;
  logic signed [15:0] nrm [3];
  logic               degen;
  logic [1:0]         ecnt;
  logic               load_out;
  logic [63:0]        strial;
  logic [46:0]        num [3];
  logic [32:0]        rtrial [3];
  vertex_t            ev;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign load_out = (state == S_EMIT) && (!res_valid || !res_stall);
  assign strial   = sres + sbit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]    = {mag[i][29:0], 17'd0} >> 1;
      num[i]    = num[i] + 47'(sres[30:0]);
      rtrial[i] = {rem[i], nlo[i][16]};
    end
    unique case (ecnt)
      2'd0:    ev = tri_q.a;
      2'd1:    ev = tri_q.b;
      default: ev = tri_q.c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) tri_q <= q_data;
    case (state)
      S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= 33'(coord(tri_q.b, 2'(i))) - 33'(coord(tri_q.a, 2'(i)));
          e2[i] <= 33'(coord(tri_q.c, 2'(i))) - 33'(coord(tri_q.a, 2'(i)));
        end
      end
      S_MUL: begin
        prod[0] <= e1[1] * e2[2];
        prod[1] <= e1[2] * e2[1];
        prod[2] <= e1[2] * e2[0];
        prod[3] <= e1[0] * e2[2];
        prod[4] <= e1[0] * e2[1];
        prod[5] <= e1[1] * e2[0];
      end
      S_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          crs[i] <= {prod[2*i][65], prod[2*i]} - {prod[2*i+1][65], prod[2*i+1]};
        end
      end
      S_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= crs[i][66];
          mag[i] <= crs[i][66] ? 66'(-crs[i]) : crs[i][65:0];
        end
        orv <= (crs[0][66] ? 66'(-crs[0]) : crs[0][65:0])
             | (crs[1][66] ? 66'(-crs[1]) : crs[1][65:0])
             | (crs[2][66] ? 66'(-crs[2]) : crs[2][65:0]);
      end
      S_NORM: begin
        // one bit per cycle until the largest magnitude has its top bit at 29
        if (orv[65:TargetBits] != '0) begin
          orv <= orv >> 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!orv[TargetBits-1] && orv != '0) begin
          orv <= orv << 1;
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      S_SQ: begin
        for (int i = 0; i < 3; i++) sq[i] <= mag[i][29:0] * mag[i][29:0];
      end
      S_SUM: begin
        sx   <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
        sres <= '0;
        sbit <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (sx >= strial) begin
          sx   <= sx - strial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      S_DIVI: begin
        dvs <= {sres[30:0], 1'b0};
        for (int i = 0; i < 3; i++) begin
          rem[i] <= 32'(num[i][46:17]);
          nlo[i] <= num[i][16:0];
          quo[i] <= '0;
        end
        dcnt <= '0;
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rtrial[i] >= {1'b0, dvs}) begin
            rem[i] <= 32'(rtrial[i] - {1'b0, dvs});
            quo[i] <= {quo[i][15:0], 1'b1};
          end else begin
            rem[i] <= rtrial[i][31:0];
            quo[i] <= {quo[i][15:0], 1'b0};
          end
          nlo[i] <= nlo[i] << 1;
        end
        dcnt <= dcnt + 5'd1;
      end
      S_FIN: begin
        for (int i = 0; i < 3; i++) begin
          if (quo[i] > 17'(NSat)) begin
            nrm[i] <= neg[i] ? -$signed(NSat) : $signed(NSat);
          end else begin
            nrm[i] <= neg[i] ? -$signed({1'b0, quo[i][14:0]})
                             : $signed({1'b0, quo[i][14:0]});
          end
        end
      end
      default: ;
    endcase
    if (state == S_NORM && orv == '0) begin
      for (int i = 0; i < 3; i++) nrm[i] <= '0;
    end
    if (load_out) begin
      res.out_x            <= ev.pos_x;
      res.out_y            <= ev.pos_y;
      res.out_z            <= ev.pos_z;
      res.out_u            <= ev.tex_u;
      res.out_v            <= ev.tex_v;
      res.normal_x         <= nrm[0];
      res.normal_y         <= nrm[1];
      res.normal_z         <= nrm[2];
      res.degenerate       <= degen;
      res.last_of_triangle <= (ecnt == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      degen     <= 1'b0;
      ecnt      <= '0;
    end else begin
      if (load_out) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE:  if (q_valid) state <= S_EDGE;
        S_EDGE:  state <= S_MUL;
        S_MUL:   state <= S_CROSS;
        S_CROSS: state <= S_ABS;
        S_ABS:   state <= S_NORM;
        S_NORM: begin
          if (orv == '0) begin
            degen <= 1'b1;
            ecnt  <= '0;
            state <= S_EMIT;
          end else if (orv[65:TargetBits] == '0 && orv[TargetBits-1]) begin
            degen <= 1'b0;
            state <= S_SQ;
          end
        end
        S_SQ:    state <= S_SUM;
        S_SUM:   state <= S_SQRT;
        S_SQRT:  if (sbit[0]) state <= S_DIVI;
        S_DIVI:  state <= S_DIV;
        S_DIV:   if (dcnt == 5'd16) state <= S_FIN;
        S_FIN: begin
          ecnt  <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load_out) begin
            ecnt <= ecnt + 2'd1;
            if (ecnt == 2'd2) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TFN_ASSERT_NOW(a_degen_zero, res_valid && res.degenerate, res.normal_x == 16'sd0 && res.normal_y == 16'sd0 && res.normal_z == 16'sd0, "degenerate item carries a nonzero normal")
  `TFN_ASSERT_NOW(a_sat, res_valid, res.normal_x != 16'sh8000 && res.normal_y != 16'sh8000 && res.normal_z != 16'sh8000, "normal component outside saturation range")
  `TFN_ASSERT_NOW(a_len_min, state == S_DIV, dvs[31:30] != 2'b00, "vector length below its lower bound")
  `TFN_ASSERT_NEXT(a_last_idle, load_out && ecnt == 2'd2, state == S_IDLE && res.last_of_triangle, "third item did not close the triangle")
endmodule
`default_nettype wire

### sv/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Groups vertices into triangles and tags each with its unit face normal.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// vtx      in         vtx_valid/stall    vertex_t (pos_x..tex_v)
// res      out        res_valid/stall    result_t (vertex, normal, flags)
//
// The front takes one vertex per cycle while vtx_stall is low; two triangles
// can wait in the queue. The back handles one triangle at a time: the one-bit
// normalizing shift, the 32-step square root, the 17-step divider, then the
// emit of its three vertices (degenerate: straight from shift to emit).
// Reset is synchronous and clears phase, queue and back-end state.
// A stalled result holds in the output register; vtx_stall is high only while
// a group waits for its third vertex and the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vtx_valid,
  output logic                  vtx_stall,
  input  wire tfn_pkg::vertex_t vtx,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output tfn_pkg::result_t      res
);
  import tfn_pkg::*;

  qwr_t qwr;
  tri_t wr_tri;
  tri_t rd_tri;
  logic q_full;
  logic q_valid;
  logic q_pop;

  tfn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .qwr       (qwr),
    .q_full    (q_full),
    .q_data    (wr_tri)
  );

  tfn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (qwr.push),
    .wr_data  (wr_tri),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (rd_tri)
  );

  tfn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (rd_tri),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );
endmodule
`default_nettype wire
